/* rtl/transport_connection_receiver_defines.svh */
// Assertion macros shared by the receiver top level.
// No dependencies.
`ifndef TRANSPORT_CONNECTION_RECEIVER_DEFINES_SVH
`define TRANSPORT_CONNECTION_RECEIVER_DEFINES_SVH
`define TCR_ASSERT_IMPLIES(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("check failed");
`define TCR_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("check failed");
`endif

/* rtl/tcr_pkg.sv */
// Types and codes of the transport connection receiver.
// No dependencies.
package tcr_pkg;
	localparam int NUM_ENTRIES = 8;
	localparam int BUFFER_BYTES = 4096;
	typedef enum logic [2:0] {K_OPEN, K_LISTEN, K_CLOSE, K_RECV, K_SEG, K_TICK} kind_t;
	localparam logic [2:0] ST_OK = 3'd0, ST_FULL = 3'd1, ST_INVALID = 3'd2,
		ST_WRONG = 3'd3, ST_NOTREADY = 3'd4, ST_IGNORED = 3'd5;
	localparam logic [1:0] CS_CLOSED = 2'd0, CS_LISTEN = 2'd1, CS_CONN = 2'd2,
		CS_CWAIT = 2'd3;
	localparam logic [1:0] SEG_SYN = 2'd0, SEG_FIN = 2'd1, SEG_DATA = 2'd2, SEG_OTHER = 2'd3;
	localparam logic [1:0] ACK_SYN = 2'd0, ACK_FIN = 2'd1, ACK_DATA = 2'd2;
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_TICK, S_OUT} fsm_t;
	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] sock_id;
		logic [15:0] local_port;
		logic [15:0] peer_port;
		logic [1:0] seg_kind;
		logic [31:0] seq_num;
		logic [12:0] length;
	} req_t;
	typedef struct packed {
		logic [2:0] status;
		logic [2:0] sock_out;
		logic [1:0] conn_state;
		logic ack_valid;
		logic [1:0] ack_type;
		logic [15:0] ack_src_port;
		logic [15:0] ack_dest_port;
		logic [31:0] ack_num;
		logic data_accepted;
		logic [11:0] append_offset;
		logic [12:0] taken_length;
	} rsp_t;
endpackage

/* rtl/tcr_if.sv */
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type T is a parameter.
interface tcr_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/transport_connection_receiver.sv */
// Transport connection receiver: connection table with an iterative scanner.
// Depends on tcr_pkg, tcr_if and transport_connection_receiver_defines.svh.
//
// Usage: requests arrive on req (valid/ready, payload tcr_pkg::req_t); one
// response per request leaves on rsp. The user must write register
// close_wait_ticks through cfg_we/cfg_wdata only while idle; the block itself
// does not enforce it. Requests are taken one at a time; ready is low
// while a request is being worked on.
// Scan: open, segment and tick walk the table one entry per cycle with a
// single port compare / timer unit; a SYN segment may make a second pass that
// shares the compare for fallback. Listen, close and recv skip the scan. A new
// request is taken in the cycle after the response is accepted. The response
// is held in an output register; a stalled receiver holds it and the block
// takes no new request until it is taken.
// Reset: all entries invalid and closed, counters zero, close_wait_ticks 1000.
module transport_connection_receiver (
	input logic clk,
	input logic arst_n,
	tcr_if.sink req,
	tcr_if.source rsp,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);
	import tcr_pkg::*;
	`include "transport_connection_receiver_defines.svh"
	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int CW = $clog2(NUM_ENTRIES + 1);
	localparam int UW = $clog2(BUFFER_BYTES + 1);

	logic [NUM_ENTRIES-1:0] valid_q, known_q;
	logic [1:0] state_q [NUM_ENTRIES];
	logic [15:0] sport_q [NUM_ENTRIES];
	logic [15:0] cport_q [NUM_ENTRIES];
	logic [31:0] eseq_q [NUM_ENTRIES];
	logic [UW-1:0] used_q [NUM_ENTRIES];
	logic [15:0] timer_q [NUM_ENTRIES];
	logic [15:0] cwt_q;

	fsm_t fsm_q, fsm_d;
	req_t r_q;
	rsp_t out_q;
	logic out_v_q;
	logic [CW-1:0] cnt_q;
	logic pass_q;
	logic found_q;
	logic [IW-1:0] hit_q;

	logic [IW-1:0] ci;
	logic cur_hit;
	assign ci = cnt_q[IW-1:0];
	always_comb begin
		cur_hit = 1'b0;
		case (r_q.kind)
			K_OPEN: cur_hit = !valid_q[ci];
			K_SEG: cur_hit = valid_q[ci] && sport_q[ci] == r_q.local_port &&
				(pass_q || (known_q[ci] && cport_q[ci] == r_q.peer_port));
			default: cur_hit = 1'b0;
		endcase
	end

	logic sid_ok;
	logic [IW-1:0] sid;
	assign sid = r_q.sock_id[IW-1:0];
	assign sid_ok = ({{(32-3){1'b0}}, r_q.sock_id} < 32'(NUM_ENTRIES)) && valid_q[sid];

	assign req.ready = (fsm_q == S_IDLE) && !out_v_q;
	assign rsp.valid = out_v_q;
	assign rsp.data = out_q;

	always_comb begin
		fsm_d = fsm_q;
		case (fsm_q)
			S_IDLE: if (req.valid && req.ready) fsm_d = S_SCAN;
			S_SCAN: begin
				if (!(r_q.kind == K_OPEN || r_q.kind == K_SEG || r_q.kind == K_TICK)
					|| (r_q.kind == K_SEG && r_q.seg_kind == SEG_OTHER))
					fsm_d = S_EXEC;
				else if (r_q.kind == K_TICK) fsm_d = S_TICK;
				else if (cur_hit || cnt_q == CW'(NUM_ENTRIES - 1)) begin
					if (!cur_hit && r_q.kind == K_SEG && r_q.seg_kind == SEG_SYN && !pass_q)
						fsm_d = S_SCAN;
					else fsm_d = S_EXEC;
				end
			end
			S_TICK: if (cnt_q == CW'(NUM_ENTRIES - 1)) fsm_d = S_OUT;
			S_EXEC: fsm_d = S_OUT;
			S_OUT: fsm_d = S_IDLE;
			default: fsm_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fsm_q <= S_IDLE;
		else fsm_q <= fsm_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cwt_q <= 16'd1000;
		else if (cfg_we) cwt_q <= cfg_wdata;
	end

	logic [IW-1:0] e;
	logic [UW:0] freeb;
	assign e = hit_q;
	assign freeb = (UW+1)'(BUFFER_BYTES) - {1'b0, used_q[e]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			known_q <= '0;
			out_v_q <= 1'b0;
			cnt_q <= '0;
			pass_q <= 1'b0;
			found_q <= 1'b0;
			hit_q <= '0;
			r_q <= '0;
			out_q <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				state_q[i] <= CS_CLOSED;
				used_q[i] <= '0;
				timer_q[i] <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
			case (fsm_q)
				S_IDLE: if (req.valid && req.ready) begin
					r_q <= req.data;
					cnt_q <= '0;
					pass_q <= 1'b0;
					found_q <= 1'b0;
					out_q <= '0;
				end
				S_SCAN: if (r_q.kind == K_OPEN ||
					(r_q.kind == K_SEG && r_q.seg_kind != SEG_OTHER)) begin
					if (cur_hit) begin
						found_q <= 1'b1;
						hit_q <= ci;
					end else if (cnt_q == CW'(NUM_ENTRIES - 1)) begin
						cnt_q <= '0;
						pass_q <= 1'b1;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_TICK: begin
					if (valid_q[ci] && state_q[ci] == CS_CWAIT) begin
						if (timer_q[ci] <= 16'd1) begin
							timer_q[ci] <= '0;
							state_q[ci] <= CS_CLOSED;
							used_q[ci] <= '0;
						end else timer_q[ci] <= timer_q[ci] - 16'd1;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_EXEC: begin
					case (r_q.kind)
						K_OPEN: if (!found_q) out_q.status <= ST_FULL;
							else begin
								valid_q[e] <= 1'b1;
								state_q[e] <= CS_CLOSED;
								sport_q[e] <= r_q.local_port;
								known_q[e] <= 1'b0;
								used_q[e] <= '0;
								timer_q[e] <= '0;
							end
						K_LISTEN, K_CLOSE, K_RECV: begin
							hit_q <= sid;
							found_q <= sid_ok;
							if (!sid_ok) out_q.status <= ST_INVALID;
							else if (r_q.kind == K_LISTEN) begin
								state_q[sid] <= CS_LISTEN;
								timer_q[sid] <= '0;
							end else if (r_q.kind == K_CLOSE) begin
								if (state_q[sid] == CS_CLOSED) valid_q[sid] <= 1'b0;
								else out_q.status <= ST_WRONG;
							end else if ({{(UW+1-13){1'b0}}, r_q.length} >
								(UW+1)'(used_q[sid]) || r_q.length > 13'(BUFFER_BYTES))
								out_q.status <= ST_NOTREADY;
							else begin
								used_q[sid] <= used_q[sid] - UW'(r_q.length);
								out_q.taken_length <= r_q.length;
							end
						end
						K_SEG: if (!found_q) out_q.status <= ST_IGNORED;
							else case (r_q.seg_kind)
								SEG_SYN: if (state_q[e] == CS_LISTEN) begin
									cport_q[e] <= r_q.peer_port;
									known_q[e] <= 1'b1;
									state_q[e] <= CS_CONN;
									eseq_q[e] <= r_q.seq_num;
									out_q.ack_valid <= 1'b1;
									out_q.ack_src_port <= sport_q[e];
									out_q.ack_dest_port <= r_q.peer_port;
									out_q.ack_num <= r_q.seq_num;
								end else if (state_q[e] == CS_CONN) begin
									out_q.ack_valid <= 1'b1;
									out_q.ack_src_port <= sport_q[e];
									out_q.ack_dest_port <= cport_q[e];
									out_q.ack_num <= eseq_q[e];
								end else out_q.status <= ST_WRONG;
								SEG_FIN: if (state_q[e] == CS_CONN || state_q[e] == CS_CWAIT) begin
									if (state_q[e] == CS_CONN) begin
										state_q[e] <= CS_CWAIT;
										timer_q[e] <= cwt_q;
									end
									out_q.ack_valid <= 1'b1;
									out_q.ack_type <= ACK_FIN;
									out_q.ack_src_port <= sport_q[e];
									out_q.ack_dest_port <= cport_q[e];
									out_q.ack_num <= eseq_q[e];
								end else out_q.status <= ST_WRONG;
								default: if (state_q[e] != CS_CONN) out_q.status <= ST_WRONG;
									else if ({{(UW+1-13){1'b0}}, r_q.length} > freeb ||
										r_q.length > 13'(BUFFER_BYTES))
										out_q.status <= ST_NOTREADY;
									else begin
										out_q.ack_valid <= 1'b1;
										out_q.ack_type <= ACK_DATA;
										out_q.ack_src_port <= sport_q[e];
										out_q.ack_dest_port <= cport_q[e];
										if (r_q.seq_num == eseq_q[e]) begin
											out_q.data_accepted <= 1'b1;
											out_q.append_offset <= 12'(used_q[e]);
											used_q[e] <= used_q[e] + UW'(r_q.length);
											eseq_q[e] <= eseq_q[e] + 32'(r_q.length);
											out_q.ack_num <= eseq_q[e] + 32'(r_q.length);
										end else out_q.ack_num <= eseq_q[e];
									end
							endcase
						K_TICK: ;
						default: out_q.status <= ST_IGNORED;
					endcase
				end
				S_OUT: begin
					if (found_q) begin
						out_q.sock_out <= 3'(hit_q);
						out_q.conn_state <= state_q[hit_q];
					end else begin
						out_q.sock_out <= '0;
						out_q.conn_state <= '0;
					end
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	`TCR_ASSERT_IMPLIES(a_ready_idle, req.ready, fsm_q == S_IDLE && !rsp.valid)
	`TCR_ASSERT_NEXT(a_out_sets_valid, fsm_q == S_OUT, rsp.valid)
	`TCR_ASSERT_IMPLIES(a_ack_fields, rsp.valid && !rsp.data.ack_valid,
		rsp.data.ack_num == 32'd0 && rsp.data.ack_type == ACK_SYN)
endmodule

/* verif/tb_transport_connection_receiver.sv */
// Testbench of the transport connection receiver: random and directed requests
// checked against a behavioral predictor of the connection table.
// Depends on tcr_pkg, tcr_if and transport_connection_receiver.
module tb_transport_connection_receiver;
	import tcr_pkg::*;

	localparam int N_ENT = 8;
	localparam int BUF_BYTES = 4096;
	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	tcr_if #(.T(req_t)) req ();
	tcr_if #(.T(rsp_t)) rsp ();

	transport_connection_receiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [15:0] wait_ticks;
	logic tab_valid [N_ENT];
	logic [1:0] tab_state [N_ENT];
	logic [15:0] tab_sport [N_ENT];
	logic [15:0] tab_cport [N_ENT];
	logic tab_known [N_ENT];
	logic [31:0] tab_seq [N_ENT];
	logic [12:0] tab_used [N_ENT];
	logic [15:0] tab_timer [N_ENT];

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];
	int errors;
	int cycles;
	bit sender_hold;
	int rx_hold_cycles;
	int rx_gap;
	int tx_gap;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int find_conn(logic [15:0] cp, logic [15:0] sp, bit fb);
		for (int i = 0; i < N_ENT; i++)
			if (tab_valid[i] && tab_known[i] && tab_cport[i] == cp && tab_sport[i] == sp)
				return i;
		if (fb)
			for (int i = 0; i < N_ENT; i++)
				if (tab_valid[i] && tab_sport[i] == sp)
					return i;
		return -1;
	endfunction

	function automatic rsp_t conn_response(req_t r);
		rsp_t o;
		int e;
		bit ok;
		e = -1;
		o = '0;
		ok = tab_valid[r.sock_id];
		case (r.kind)
			K_OPEN: begin
				for (int i = 0; i < N_ENT; i++)
					if (!tab_valid[i] && e < 0)
						e = i;
				if (e < 0) begin
					o.status = ST_FULL;
				end else begin
					tab_valid[e] = 1'b1;
					tab_state[e] = CS_CLOSED;
					tab_sport[e] = r.local_port;
					tab_known[e] = 1'b0;
					tab_used[e] = '0;
					tab_timer[e] = '0;
				end
			end
			K_LISTEN: begin
				if (!ok) begin
					o.status = ST_INVALID;
				end else begin
					e = r.sock_id;
					tab_state[e] = CS_LISTEN;
					tab_timer[e] = '0;
				end
			end
			K_CLOSE: begin
				if (!ok) begin
					o.status = ST_INVALID;
				end else begin
					e = r.sock_id;
					if (tab_state[e] == CS_CLOSED)
						tab_valid[e] = 1'b0;
					else
						o.status = ST_WRONG;
				end
			end
			K_RECV: begin
				if (!ok) begin
					o.status = ST_INVALID;
				end else begin
					e = r.sock_id;
					if (tab_used[e] < r.length) begin
						o.status = ST_NOTREADY;
					end else begin
						tab_used[e] = tab_used[e] - r.length;
						o.taken_length = r.length;
					end
				end
			end
			K_SEG: begin
				if (r.seg_kind == SEG_OTHER) begin
					o.status = ST_IGNORED;
				end else begin
					e = find_conn(r.peer_port, r.local_port, r.seg_kind == SEG_SYN);
					if (e < 0) begin
						o.status = ST_IGNORED;
					end else if (r.seg_kind == SEG_SYN) begin
						if (tab_state[e] == CS_LISTEN) begin
							tab_cport[e] = r.peer_port;
							tab_known[e] = 1'b1;
							tab_state[e] = CS_CONN;
							tab_seq[e] = r.seq_num;
							o.ack_valid = 1'b1;
						end else if (tab_state[e] == CS_CONN) begin
							o.ack_valid = 1'b1;
						end else begin
							o.status = ST_WRONG;
						end
						o.ack_type = ACK_SYN;
					end else if (r.seg_kind == SEG_FIN) begin
						if (tab_state[e] == CS_CONN) begin
							tab_state[e] = CS_CWAIT;
							tab_timer[e] = wait_ticks;
							o.ack_valid = 1'b1;
						end else if (tab_state[e] == CS_CWAIT) begin
							o.ack_valid = 1'b1;
						end else begin
							o.status = ST_WRONG;
						end
						o.ack_type = o.ack_valid ? ACK_FIN : ACK_SYN;
					end else begin
						if (tab_state[e] != CS_CONN) begin
							o.status = ST_WRONG;
						end else if (BUF_BYTES < tab_used[e]
								|| BUF_BYTES - tab_used[e] < r.length) begin
							o.status = ST_NOTREADY;
						end else begin
							if (r.seq_num == tab_seq[e]) begin
								o.data_accepted = 1'b1;
								o.append_offset = tab_used[e][11:0];
								tab_used[e] = tab_used[e] + r.length;
								tab_seq[e] = tab_seq[e] + r.length;
							end
							o.ack_valid = 1'b1;
							o.ack_type = ACK_DATA;
						end
					end
					if (o.ack_valid) begin
						o.ack_src_port = tab_sport[e];
						o.ack_dest_port = tab_cport[e];
						o.ack_num = tab_seq[e];
					end
				end
			end
			K_TICK: begin
				for (int i = 0; i < N_ENT; i++)
					if (tab_valid[i] && tab_state[i] == CS_CWAIT) begin
						if (tab_timer[i] <= 1) begin
							tab_timer[i] = '0;
							tab_state[i] = CS_CLOSED;
							tab_used[i] = '0;
						end else begin
							tab_timer[i] = tab_timer[i] - 16'd1;
						end
					end
			end
			default: o.status = ST_IGNORED;
		endcase
		if (e >= 0) begin
			o.sock_out = e[2:0];
			o.conn_state = tab_state[e];
		end
		return o;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
			tx_gap <= 0;
		end else if (req.valid && !req.ready) begin
		end else if (tx_gap > 0) begin
			req.valid <= 1'b0;
			tx_gap <= tx_gap - 1;
		end else if (pending_reqs.size() > 0 && !sender_hold) begin
			req.data <= pending_reqs[0];
			expected_rsps.push_back(conn_response(pending_reqs[0]));
			void'(pending_reqs.pop_front());
			req.valid <= 1'b1;
			tx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
		end else begin
			req.valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rx_gap <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response %p", $time, rsp.data);
					errors <= errors + 1;
				end else begin
					if (rsp.data !== expected_rsps[0]) begin
						$display("%0t: expected %p actual %p", $time, expected_rsps[0],
							rsp.data);
						errors <= errors + 1;
					end
					void'(expected_rsps.pop_front());
				end
			end
			if (rx_hold_cycles > 0) begin
				rsp.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rsp.ready <= 1'b0;
				rx_gap <= rx_gap - 1;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp.valid && rsp.ready)
					rx_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
			end
		end
	end

	always @(posedge clk) begin
		if (rx_hold_cycles > 0)
			rx_hold_cycles <= rx_hold_cycles - 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_transport_connection_receiver NOT OK");
			$finish;
		end
	end

	function automatic req_t make_req(kind_t k, int sid, int sp, int cp, int st,
			logic [31:0] sq, int len);
		req_t r;
		r.kind = k;
		r.sock_id = sid[2:0];
		r.local_port = sp[15:0];
		r.peer_port = cp[15:0];
		r.seg_kind = st[1:0];
		r.seq_num = sq;
		r.length = len[12:0];
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req.valid)
			@(posedge clk);
		repeat (2 * N_ENT + 10) @(posedge clk);
	endtask

	task automatic write_wait_ticks(logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		wait_ticks = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// connection sequence with random content on a small set of local ports
	task automatic queue_session(int sid);
		int sp;
		int cp;
		logic [31:0] sq;
		int n;
		req_t r;
		sp = $urandom_range(0, 3);
		cp = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(100, 103);
		sq = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 : $urandom;
		pending_reqs.push_back(make_req(K_OPEN, 0, sp, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_LISTEN, sid, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, sp, cp, SEG_SYN, sq, 0));
		n = $urandom_range(2, 10);
		for (int i = 0; i < n; i++) begin
			int len;
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4096)
				: $urandom_range(0, 600);
			r = make_req(K_SEG, 0, sp, cp, SEG_DATA, sq, len);
			if ($urandom_range(0, 4) == 0)
				r.seq_num = $urandom;
			else
				sq = sq + len;
			pending_reqs.push_back(r);
			if ($urandom_range(0, 2) == 0)
				pending_reqs.push_back(make_req(K_RECV, sid, 0, 0, 0, 0,
					$urandom_range(0, 1200)));
		end
		if ($urandom_range(0, 1))
			pending_reqs.push_back(make_req(K_SEG, 0, sp, cp, SEG_FIN, 0, 0));
		for (int i = $urandom_range(0, 5); i > 0; i--)
			pending_reqs.push_back(make_req(K_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_CLOSE, sid, 0, 0, 0, 0, 0));
	endtask

	task automatic queue_noise();
		req_t r;
		r.kind = 3'($urandom_range(0, 7));
		r.sock_id = 3'($urandom_range(0, 7));
		r.local_port = 16'($urandom);
		r.peer_port = 16'($urandom);
		r.seg_kind = 2'($urandom_range(0, 3));
		r.seq_num = $urandom;
		r.length = 13'($urandom);
		if ($urandom_range(0, 1)) begin
			r.local_port = 16'($urandom_range(0, 3));
			r.peer_port = 16'($urandom_range(100, 103));
		end
		if ($urandom_range(0, 3) != 0)
			r.length = 13'($urandom_range(0, 4096));
		pending_reqs.push_back(r);
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		sender_hold = 1'b0;
		rx_hold_cycles = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		wait_ticks = 16'd1000;
		for (int i = 0; i < N_ENT; i++) begin
			tab_valid[i] = 1'b0;
			tab_state[i] = CS_CLOSED;
			tab_sport[i] = '0;
			tab_cport[i] = '0;
			tab_known[i] = 1'b0;
			tab_seq[i] = '0;
			tab_used[i] = '0;
			tab_timer[i] = '0;
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		write_wait_ticks(16'd1);
		pending_reqs.push_back(make_req(K_RECV, 7, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_SYN, 0, 0));
		for (int i = 0; i < N_ENT + 1; i++)
			pending_reqs.push_back(make_req(K_OPEN, 0, (i == 0) ? 65535 : i, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_LISTEN, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_SYN, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_DATA, 32'hFFFF_FFFF,
			4096));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_DATA, 32'd5, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_DATA, 32'hFFF, 1));
		pending_reqs.push_back(make_req(K_RECV, 0, 0, 0, 0, 0, 4097));
		pending_reqs.push_back(make_req(K_RECV, 0, 0, 0, 0, 0, 4096));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_OTHER, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_FIN, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_FIN, 0, 0));
		pending_reqs.push_back(make_req(K_CLOSE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(K_SEG, 0, 65535, 65535, SEG_SYN, 0, 0));
		pending_reqs.push_back(make_req(K_CLOSE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(kind_t'(3'd6), 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(kind_t'(3'd7), 0, 0, 0, 0, 0, 0));
		wait_drained();

		// random phases under several close-wait settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_wait_ticks(16'd0);
				1: write_wait_ticks(16'd65535);
				default: write_wait_ticks(16'($urandom_range(1, 6)));
			endcase
			for (int s = 0; s < 17; s++) begin
				if ($urandom_range(0, 3) == 0)
					for (int k = 0; k < 3; k++)
						queue_noise();
				else
					queue_session($urandom_range(0, N_ENT - 1));
			end
			if (ph == 2)
				rx_hold_cycles = 400;
			if (ph == 4) begin
				while (pending_reqs.size() > 60)
					@(posedge clk);
				sender_hold = 1'b1;
				while (expected_rsps.size() > 0 || req.valid)
					@(posedge clk);
				sender_hold = 1'b0;
			end
			wait_drained();
		end
		if (errors == 0)
			$display("tb_transport_connection_receiver OK");
		else
			$display("tb_transport_connection_receiver NOT OK");
		$finish;
	end
endmodule
